// File: rtl/dpt_pkg.sv
// Shared types and constants for the debounced pulse tachometer.
package dpt_pkg;

  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 8;
  localparam int LOCK_W     = 20;
  localparam int SCALE_W    = 30;
  localparam int DIVIDEND_W = COUNT_W + SCALE_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [SCALE_W-1:0] SCALE         = SCALE_W'(960000000);
  localparam logic [TIME_W-1:0]  SAT           = '1;
  localparam logic [LOCK_W-1:0]  LOCKOUT_RESET = LOCK_W'(12000);
  localparam logic [COUNT_W-1:0] PULSES_RESET  = COUNT_W'(15);

  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // word address, paddr[2]
  localparam logic REG_LOCKOUT = 1'b0;
  localparam logic REG_PULSES  = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TIME_W-1:0] timestamp_us;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] rpm_x16;
    logic [TIME_W-1:0] elapsed_us;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [TIME_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/dpt_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module dpt_div (
  input  logic              clk,
  input  logic              rst,
  input  dpt_pkg::div_req_t req,
  output dpt_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [dpt_pkg::DIV_CNT_W-1:0]  cnt;
  logic [dpt_pkg::TIME_W-1:0]     rem;
  logic [dpt_pkg::TIME_W-1:0]     divisor;
  logic [dpt_pkg::DIVIDEND_W-1:0] quo;
  logic [dpt_pkg::TIME_W:0]       shifted;
  logic [dpt_pkg::TIME_W:0]       diff;
  logic                           ge;

  assign shifted = {rem, quo[dpt_pkg::DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= dpt_pkg::DIV_CNT_W'(dpt_pkg::DIVIDEND_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[dpt_pkg::TIME_W-1:0] : shifted[dpt_pkg::TIME_W-1:0];
      quo <= {quo[dpt_pkg::DIVIDEND_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: rtl/debounced_pulse_tachometer.sv
// Top level: register port, event sequencer and shared divider.
// Start, stop, unused codes, edges while stopped: taken in S_IDLE, handled in S_EVAL, back to S_IDLE.
// Edge handled while running, no result: S_EVAL, then S_CHECK, then back to S_IDLE.
// Completing edge: S_EVAL, S_CHECK, S_MUL, S_DIV (skipped at zero elapsed time), then S_HOLD until
//   the result is loaded; the next transfer can come in the cycle after the result is loaded.
// Synchronous active-high reset: registers to defaults, measurement stopped.
module debounced_pulse_tachometer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpt_pkg::DATA_W-1:0]  pwdata,
  output logic [dpt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  dpt_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output dpt_pkg::result_t            result
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_CHECK = 6'b000100,
    S_MUL   = 6'b001000,
    S_DIV   = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  state_t                        state;
  logic [dpt_pkg::LOCK_W-1:0]    lockout_us;
  logic [dpt_pkg::COUNT_W-1:0]   pulses_per_measure;
  logic                          is_running;
  logic                          fresh_run;
  logic [dpt_pkg::TIME_W-1:0]    reference_time;
  logic [dpt_pkg::TIME_W-1:0]    last_accepted_time;
  logic [dpt_pkg::COUNT_W-1:0]   edge_count;
  dpt_pkg::item_t                cur;
  logic [dpt_pkg::TIME_W-1:0]    elapsed;
  logic [dpt_pkg::TIME_W-1:0]    rpm;
  logic [dpt_pkg::TIME_W-1:0]    last_eff;
  logic [dpt_pkg::TIME_W-1:0]    gap;
  logic                          cfg_wr;
  logic                          load_result;
  dpt_pkg::div_req_t             div_req;
  dpt_pkg::div_rsp_t             div_rsp;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_us         <= dpt_pkg::LOCKOUT_RESET;
      pulses_per_measure <= dpt_pkg::PULSES_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        dpt_pkg::REG_LOCKOUT: lockout_us         <= pwdata[dpt_pkg::LOCK_W-1:0];
        dpt_pkg::REG_PULSES:  pulses_per_measure <= pwdata[dpt_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dpt_pkg::REG_LOCKOUT: prdata = dpt_pkg::DATA_W'(lockout_us);
      dpt_pkg::REG_PULSES:  prdata = dpt_pkg::DATA_W'(pulses_per_measure);
      default:              prdata = '0;
    endcase
  end

  assign last_eff = fresh_run ? cur.timestamp_us : last_accepted_time;
  assign gap      = cur.timestamp_us - last_eff;

  assign div_req.start    = (state == S_MUL) && (elapsed != '0);
  assign div_req.dividend = dpt_pkg::DIVIDEND_W'(edge_count) *
                            dpt_pkg::DIVIDEND_W'(dpt_pkg::SCALE);
  assign div_req.divisor  = elapsed;

  dpt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign load_result = (state == S_HOLD) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      is_running         <= 1'b0;
      fresh_run          <= 1'b0;
      reference_time     <= '0;
      last_accepted_time <= '0;
      edge_count         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_IDLE;
          case (cur.opcode)
            dpt_pkg::OP_START: begin
              is_running <= 1'b1;
              fresh_run  <= 1'b1;
            end
            dpt_pkg::OP_STOP: is_running <= 1'b0;
            dpt_pkg::OP_EDGE: begin
              if (is_running) begin
                state <= S_CHECK;
                if (fresh_run) begin
                  reference_time <= cur.timestamp_us;
                  fresh_run      <= 1'b0;
                end
                if (gap > dpt_pkg::TIME_W'(lockout_us)) begin
                  edge_count         <= edge_count + 1'b1;
                  last_accepted_time <= cur.timestamp_us;
                end else begin
                  last_accepted_time <= last_eff;
                end
              end
            end
            default: ;
          endcase
        end
        S_CHECK: begin
          if (edge_count >= pulses_per_measure) begin
            is_running     <= 1'b0;
            reference_time <= last_accepted_time;
            state          <= S_MUL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          edge_count <= '0;
          state      <= (elapsed == '0) ? S_HOLD : S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) state <= S_HOLD;
        end
        S_HOLD: begin
          if (load_result) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) cur <= item;
    if (state == S_CHECK) elapsed <= last_accepted_time - reference_time;
    if (state == S_MUL) rpm <= dpt_pkg::SAT;
    if (state == S_DIV && div_rsp.done) begin
      rpm <= (div_rsp.quotient[dpt_pkg::DIVIDEND_W-1:dpt_pkg::TIME_W] != '0) ?
             dpt_pkg::SAT : div_rsp.quotient[dpt_pkg::TIME_W-1:0];
    end
    if (load_result) begin
      result.rpm_x16    <= rpm;
      result.elapsed_us <= elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/dpt_checker.sv
// Port-level checks for the tachometer, bound to the top level.
module dpt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic                       result_valid,
  input logic                       result_ready,
  input dpt_pkg::result_t           result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous one still in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_zero_elapsed_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.elapsed_us == '0 |-> result.rpm_x16 == dpt_pkg::SAT)
    else $error("zero elapsed time not saturated");

endmodule

bind debounced_pulse_tachometer dpt_checker u_dpt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// File: dv/tach_monitor.sv
// Tachometer monitor: mirrors registers and measurement state, checks reads and speed results.
module tach_monitor import dpt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  input  logic              item_valid,
  input  logic              item_ready,
  input  item_t             item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  result_t           result,
  output int                errors,
  output int                outstanding
);

  logic [LOCK_W-1:0]  lockout;
  logic [COUNT_W-1:0] target;
  logic               running;
  logic               fresh;
  logic [TIME_W-1:0]  ref_time;
  logic [TIME_W-1:0]  last_time;
  logic [COUNT_W-1:0] pulses;
  result_t            speed_q[$];
  int                 errs = 0;

  function automatic logic [TIME_W-1:0] rpm_of(logic [COUNT_W-1:0] n, logic [TIME_W-1:0] el);
    logic [63:0] q;
    if (el == '0) return SAT;
    q = (64'(n) * 64'(SCALE)) / 64'(el);
    return (q > 64'(SAT)) ? SAT : q[TIME_W-1:0];
  endfunction

  task automatic take_event(input item_t it);
    logic [TIME_W-1:0] gap;
    result_t           r;
    case (it.opcode)
      OP_START: begin
        running = 1'b1;
        fresh   = 1'b1;
      end
      OP_STOP: running = 1'b0;
      OP_EDGE: begin
        if (running) begin
          if (fresh) begin
            ref_time  = it.timestamp_us;
            last_time = it.timestamp_us;
            fresh     = 1'b0;
          end
          gap = it.timestamp_us - last_time;
          if (gap > TIME_W'(lockout)) begin
            pulses    = pulses + 1'b1;
            last_time = it.timestamp_us;
          end
          if (pulses >= target) begin
            r.elapsed_us = last_time - ref_time;
            r.rpm_x16    = rpm_of(pulses, r.elapsed_us);
            speed_q.push_back(r);
            running  = 1'b0;
            ref_time = last_time;
            pulses   = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t           want;
    logic [DATA_W-1:0] reg_val;
    if (rst) begin
      lockout   = LOCKOUT_RESET;
      target    = PULSES_RESET;
      running   = 1'b0;
      fresh     = 1'b0;
      ref_time  = '0;
      last_time = '0;
      pulses    = '0;
      speed_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_LOCKOUT) lockout = pwdata[LOCK_W-1:0];
          else target = pwdata[COUNT_W-1:0];
        end else begin
          reg_val = (paddr[2] == REG_LOCKOUT) ? DATA_W'(lockout) : DATA_W'(target);
          if (prdata !== reg_val) begin
            $display("%0t: register read at %0d expected %0d actual %0d",
                     $time, paddr, reg_val, prdata);
            errs++;
          end
        end
      end
      if (result_valid && result_ready) begin
        if (speed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual rpm_x16 %0d elapsed_us %0d",
                   $time, result.rpm_x16, result.elapsed_us);
          errs++;
        end else begin
          want = speed_q.pop_front();
          if (result.rpm_x16 !== want.rpm_x16) begin
            $display("%0t: rpm_x16 expected %0d actual %0d", $time, want.rpm_x16,
                     result.rpm_x16);
            errs++;
          end
          if (result.elapsed_us !== want.elapsed_us) begin
            $display("%0t: elapsed_us expected %0d actual %0d", $time, want.elapsed_us,
                     result.elapsed_us);
            errs++;
          end
        end
      end
      if (item_valid && item_ready) take_event(item);
    end
    errors      <= errs;
    outstanding <= speed_q.size();
  end

endmodule

// File: dv/testbench.sv
// Testbench top: clock, reset, register setup, event stimulus and verdict for the tachometer.
module testbench;
  import dpt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 60;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              item_valid = 1'b0;
  logic              item_ready;
  item_t             item_in = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  result_t           result_out;
  int                errors;
  int                outstanding;

  int                send_idle = 22;
  int                recv_idle = 56;
  int                hold_req = 0;
  int                handled = 0;

  // stimulus-side view of the measurement, used to shape sequences
  logic [LOCK_W-1:0]  lock_set = LOCKOUT_RESET;
  logic [COUNT_W-1:0] target_set = PULSES_RESET;
  bit                 run_on = 0;
  bit                 fresh_on = 0;
  int                 cnt = 0;
  logic [TIME_W-1:0]  last_good = '0;

  always #2 clk = ~clk;

  debounced_pulse_tachometer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready), .item(item_in),
    .result_valid(result_valid), .result_ready(result_ready), .result(result_out)
  );

  tach_monitor mon (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready), .item(item_in),
    .result_valid(result_valid), .result_ready(result_ready), .result(result_out),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    #(4 * 1000000);
    $display("FAILURE");
    $finish;
  end

  task automatic send_ev(logic [1:0] op, logic [TIME_W-1:0] ts, bit counted);
    item_t it;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    it.opcode       = op;
    it.timestamp_us = ts;
    item_valid <= 1'b1;
    item_in    <= it;
    do @(posedge clk); while (!item_ready);
    if (counted) handled++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(bit wr, logic idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] lock, logic [31:0] tgt);
    drain();
    reg_access(1'b1, REG_LOCKOUT, ($urandom & 32'hFFF0_0000) | {12'h0, lock[LOCK_W-1:0]});
    reg_access(1'b0, REG_LOCKOUT, '0);
    reg_access(1'b1, REG_PULSES, ($urandom & 32'hFFFF_FF00) | {24'h0, tgt[COUNT_W-1:0]});
    reg_access(1'b0, REG_PULSES, '0);
    lock_set   = lock[LOCK_W-1:0];
    target_set = tgt[COUNT_W-1:0];
  endtask

  task automatic start_ev();
    send_ev(OP_START, $urandom, 1);
    run_on   = 1;
    fresh_on = 1;
  endtask

  task automatic stop_ev();
    send_ev(OP_STOP, $urandom, 1);
    run_on = 0;
  endtask

  task automatic edge_ev(bit good);
    logic [TIME_W-1:0] ts;
    logic [TIME_W-1:0] extra;
    if (fresh_on) begin
      ts        = $urandom;
      last_good = ts;
      fresh_on  = 0;
    end else if (good) begin
      if ($urandom_range(99) < 10) extra = $urandom_range(0, 32'hFFFF_FFFE - 32'(lock_set));
      else extra = $urandom_range(0, 300);
      ts        = last_good + 32'(lock_set) + 32'd1 + extra;
      last_good = ts;
      cnt++;
    end else begin
      ts = last_good + $urandom_range(0, 32'(lock_set));
    end
    send_ev(OP_EDGE, ts, 1);
    if (cnt >= target_set) begin
      cnt    = 0;
      run_on = 0;
    end
  endtask

  task automatic run_phase(int quota);
    int goal;
    int pick;
    goal = handled + quota;
    while (handled < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        start_ev();
        while (run_on) begin
          if ($urandom_range(99) < 3) begin
            stop_ev();
            start_ev();
          end
          edge_ev($urandom_range(99) < 75);
        end
      end else if (pick < 90) begin
        start_ev();
        repeat ($urandom_range(0, 3)) if (run_on) edge_ev($urandom_range(99) < 50);
        if (run_on) stop_ev();
      end else begin
        case ($urandom_range(2))
          0: send_ev(OP_UNUSED, $urandom, 0);
          1: send_ev(OP_EDGE, $urandom, 0);
          default: send_ev(OP_STOP, $urandom, 0);
        endcase
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: ignored events, lockout boundary across the time wrap
    send_ev(OP_EDGE,   32'h0000_0000, 0);
    send_ev(OP_UNUSED, 32'hFFFF_FFFF, 0);
    send_ev(OP_STOP,   32'h0000_0005, 0);
    send_ev(OP_START,  32'h0000_0064, 0);
    send_ev(OP_EDGE,   32'hFFFF_FFF0, 0);
    send_ev(OP_EDGE,   32'h0000_2ED0, 0);
    send_ev(OP_EDGE,   32'h0000_2ED1, 0);
    send_ev(OP_STOP,   32'h0000_3000, 0);
    send_ev(OP_EDGE,   32'h1000_0000, 0);
    send_ev(OP_START,  32'h1000_0001, 0);

    // retained count meets a lowered target on the first edge: zero elapsed
    set_config(0, 1);
    send_ev(OP_EDGE,   32'h0000_0500, 0);
    send_ev(OP_START,  32'h0000_0600, 0);
    send_ev(OP_EDGE,   32'd1000, 0);
    send_ev(OP_EDGE,   32'd1001, 0);
    send_ev(OP_START,  32'h0000_0000, 0);
    send_ev(OP_EDGE,   32'h0000_0000, 0);
    send_ev(OP_EDGE,   32'hFFFF_FFFF, 0);

    // elapsed wraps to one microsecond over five pulses: quotient overflows
    set_config(0, 5);
    send_ev(OP_START,  32'h0000_0000, 0);
    send_ev(OP_EDGE,   32'h0000_0000, 0);
    send_ev(OP_EDGE,   32'h4000_0000, 0);
    send_ev(OP_EDGE,   32'h8000_0000, 0);
    send_ev(OP_EDGE,   32'hC000_0000, 0);
    send_ev(OP_EDGE,   32'hFFFF_FFFF, 0);
    send_ev(OP_EDGE,   32'h0000_0001, 0);
    cnt    = 0;
    run_on = 0;

    set_config(500, 3);
    run_phase(350);
    set_config(0, 1);
    run_phase(200);

    send_idle = 56;
    recv_idle = 22;
    set_config(1000000, 8);
    run_phase(300);
    set_config(32'h000F_FFFF, 0);
    run_phase(150);
    set_config(37, 255);
    run_phase(150);

    send_idle = 0;
    recv_idle = 0;
    set_config(100, 2);
    hold_req = 1;
    run_phase(250);
    set_config($urandom_range(0, 5000), $urandom_range(1, 10));
    run_phase(300);

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/dpt_pkg.sv
rtl/dpt_div.sv
rtl/debounced_pulse_tachometer.sv
rtl/dpt_checker.sv
dv/tach_monitor.sv
dv/testbench.sv
